// ===== sv/lra_pkg.sv =====
package lra_pkg;

	localparam int MAX_SPOTS_DEF   = 64;
	localparam int WEIGHT_BITS_DEF = 24;

	localparam int TOTAL_W   = 32;
	localparam int SHARE_W   = 32;
	localparam int IDX_OUT_W = 6;
	localparam int CNT_OUT_W = 7;
	localparam int SUM_OUT_W = 30;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_COUNT = 2'd1,
		ST_NOPOS = 2'd2,
		ST_TOTAL = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_TOTAL = 1'b0,
		REG_SPOTS = 1'b1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_LOAD,
		S_CHECK,
		S_CRD,
		S_CMUL,
		S_CDIV,
		S_CWAIT,
		S_CWR,
		S_LEFT,
		S_RRD_I,
		S_RGET_I,
		S_RSCAN,
		S_RDRAIN,
		S_INC_RD,
		S_INC_WR,
		S_ERD,
		S_ECAP,
		S_EOUT
	} state_t;

endpackage

// ===== sv/lra_mem.sv =====
module lra_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 63
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/lra_div.sv =====
module lra_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fit;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fit   = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(NUM_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fit};
			rem_q <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = num_q;
	assign rem  = rem_q;

endmodule

// ===== sv/largest_remainder_apportioner.sv =====
// Largest-remainder share apportioner.
// Weights stream in on the input channel (weight, last_weight), one word per
// cycle while in_ready is high; words that fit are stored in the spot memory.
// The word with last_weight set closes the list. The block then checks it
// (count, then positivity, then total), gives one share to every positive
// spot, splits the rest as floor(D*w/T) and hands the leftover units to the
// largest remainders, ties to the lower index. One result word per loaded
// spot follows on the output channel; a failed check yields a single word
// with is_last set and the error status.
// Flow: evaluation of each positive spot waits on the bit-serial divider;
// ranking, when leftover units remain, scans every loaded spot for each
// positive spot and rewrites each spot that gets a unit, all paced by the
// single spot memory. Each result word is read, captured and then offered,
// held through any receiver stall.
// in_ready is low from the last word until the final result is taken; a
// stalled receiver simply holds the current result word in its register.
// Reset clears the run counters and registers (requested_total = 1,
// spot_count = 1); the spot memory is not cleared, it is written before read.
// The configuration channel is always ready; write it only while idle.
module largest_remainder_apportioner
	import lra_pkg::*;
#(
	parameter int MAX_SPOTS   = MAX_SPOTS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [WEIGHT_BITS-1:0] weight,
	input  logic                   last_weight,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [IDX_OUT_W-1:0]   spot_index,
	output logic [SHARE_W-1:0]     shares,
	output logic [1:0]             status,
	output logic [CNT_OUT_W-1:0]   removed_count,
	output logic [SUM_OUT_W-1:0]   weight_sum,
	output logic                   is_last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [0:0]             cfg_index,
	input  logic [TOTAL_W-1:0]     cfg_data
);

	localparam int IDX_W   = $clog2(MAX_SPOTS);
	localparam int CNT_W   = $clog2(MAX_SPOTS + 1);
	localparam int SUM_W   = WEIGHT_BITS + CNT_W;
	localparam int PROD_W  = TOTAL_W + WEIGHT_BITS;
	localparam int POS_BIT = SHARE_W + SUM_W;
	localparam int ENT_W   = POS_BIT + 1;

	// memory entry: {positive, weight or remainder, share}

	state_t state_q, state_d;

	logic [TOTAL_W-1:0]   req_total_q;
	logic [CNT_OUT_W-1:0] spot_cnt_q;

	logic [CNT_W-1:0] load_cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] pos_cnt_q;
	logic             ovf_q;

	logic [TOTAL_W-1:0] dist_q;
	logic [TOTAL_W-1:0] assigned_q;
	logic [TOTAL_W-1:0] leftover_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   rank_q;
	logic               jv_s1;
	logic [CNT_W-1:0]   jidx_s1;
	logic [SUM_W-1:0]   cur_rem_q;
	logic               cur_pos_q;
	logic [PROD_W-1:0]  prod_q;

	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [SHARE_W-1:0]   out_shares_q;
	status_t              out_status_q;
	logic [CNT_OUT_W-1:0] out_removed_q;
	logic                 out_last_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic [ENT_W-1:0] mem_rdata;

	logic              div_start;
	logic              div_busy;
	logic [PROD_W-1:0] div_quo;
	logic [SUM_W-1:0]  div_rem;

	logic               in_acc;
	logic               out_acc;
	logic               room;
	logic               last_i;
	logic               hit;
	logic [CNT_W-1:0]   rank_nx;
	logic               win;
	logic [TOTAL_W-1:0] left_nx;
	status_t            chk_status;
	logic [SHARE_W-1:0] rd_share;
	logic [SUM_W-1:0]   rd_rem;
	logic               rd_pos;

	lra_mem #(
		.DEPTH (MAX_SPOTS),
		.WIDTH (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lra_div #(
		.NUM_W (PROD_W),
		.DEN_W (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (sum_q),
		.busy   (div_busy),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign rd_share = mem_rdata[SHARE_W-1:0];
	assign rd_rem   = mem_rdata[POS_BIT-1:SHARE_W];
	assign rd_pos   = mem_rdata[POS_BIT];

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;
	assign room    = load_cnt_q < CNT_W'(MAX_SPOTS);
	assign last_i  = (i_q + CNT_W'(1)) == load_cnt_q;
	assign left_nx = dist_q - assigned_q;

	// remainder j outranks remainder i: larger, or equal at a lower index
	assign hit = jv_s1 && rd_pos && (jidx_s1 != i_q) &&
		((rd_rem > cur_rem_q) || ((rd_rem == cur_rem_q) && (jidx_s1 < i_q)));
	assign rank_nx = rank_q + CNT_W'(hit);
	assign win     = TOTAL_W'(rank_nx) < leftover_q;

	always_comb begin
		priority if (ovf_q || (CNT_OUT_W'(load_cnt_q) != spot_cnt_q)) begin
			chk_status = ST_COUNT;
		end else if (pos_cnt_q == '0) begin
			chk_status = ST_NOPOS;
		end else if (req_total_q < TOTAL_W'(pos_cnt_q)) begin
			chk_status = ST_TOTAL;
		end else begin
			chk_status = ST_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_acc && last_weight) state_d = S_CHECK;
			end
			S_CHECK:  state_d = (chk_status != ST_OK) ? S_EOUT : S_CRD;
			S_CRD:    state_d = S_CMUL;
			S_CMUL:   state_d = S_CDIV;
			S_CDIV:   state_d = cur_pos_q ? S_CWAIT : S_CWR;
			S_CWAIT: begin
				if (!div_busy) state_d = S_CWR;
			end
			S_CWR:    state_d = last_i ? S_LEFT : S_CRD;
			S_LEFT:   state_d = (left_nx == '0) ? S_ERD : S_RRD_I;
			S_RRD_I:  state_d = S_RGET_I;
			S_RGET_I: begin
				if (rd_pos) state_d = S_RSCAN;
				else state_d = last_i ? S_ERD : S_RRD_I;
			end
			S_RSCAN: begin
				if (j_q == load_cnt_q - CNT_W'(1)) state_d = S_RDRAIN;
			end
			S_RDRAIN: begin
				if (win) state_d = S_INC_RD;
				else state_d = last_i ? S_ERD : S_RRD_I;
			end
			S_INC_RD: state_d = S_INC_WR;
			S_INC_WR: state_d = last_i ? S_ERD : S_RRD_I;
			S_ERD:    state_d = S_ECAP;
			S_ECAP:   state_d = S_EOUT;
			S_EOUT: begin
				if (out_ready) state_d = out_last_q ? S_LOAD : S_ERD;
			end
			default:  state_d = S_LOAD;
		endcase
	end

	// memory, divider and handshake controls
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = i_q[IDX_W-1:0];
		mem_wdata = {rd_pos, rd_rem, rd_share + SHARE_W'(1)};
		mem_re    = 1'b0;
		mem_raddr = i_q[IDX_W-1:0];
		div_start = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_ready  = 1'b1;
				mem_we    = in_valid && room;
				mem_waddr = load_cnt_q[IDX_W-1:0];
				mem_wdata = {weight != '0, SUM_W'(weight), SHARE_W'(0)};
			end
			S_CRD, S_RRD_I, S_INC_RD, S_ERD: begin
				mem_re = 1'b1;
			end
			S_CDIV: begin
				div_start = cur_pos_q;
			end
			S_CWR: begin
				mem_we    = 1'b1;
				mem_wdata = cur_pos_q ?
					{1'b1, div_rem, div_quo[SHARE_W-1:0] + SHARE_W'(1)} : '0;
			end
			S_RSCAN: begin
				mem_re    = 1'b1;
				mem_raddr = j_q[IDX_W-1:0];
			end
			S_INC_WR: begin
				mem_we = 1'b1;
			end
			S_EOUT: begin
				out_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_total_q <= TOTAL_W'(1);
			spot_cnt_q  <= CNT_OUT_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOTAL: req_total_q <= cfg_data;
				REG_SPOTS: spot_cnt_q  <= cfg_data[CNT_OUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control state and run counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			load_cnt_q <= '0;
			sum_q      <= '0;
			pos_cnt_q  <= '0;
			ovf_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			rank_q     <= '0;
			jv_s1      <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			jv_s1   <= (state_q == S_RSCAN);
			if (in_acc) begin
				if (room) begin
					load_cnt_q <= load_cnt_q + CNT_W'(1);
					sum_q      <= sum_q + SUM_W'(weight);
					pos_cnt_q  <= pos_cnt_q + CNT_W'(weight != '0);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (out_acc && out_last_q) begin
				load_cnt_q <= '0;
				sum_q      <= '0;
				pos_cnt_q  <= '0;
				ovf_q      <= 1'b0;
			end
			unique case (state_q)
				S_CHECK: begin
					i_q        <= '0;
					out_last_q <= 1'b1;
				end
				S_CWR, S_INC_WR: begin
					i_q <= last_i ? '0 : i_q + CNT_W'(1);
				end
				S_LEFT: begin
					i_q <= '0;
				end
				S_RGET_I: begin
					j_q    <= '0;
					rank_q <= '0;
					if (!rd_pos) i_q <= last_i ? '0 : i_q + CNT_W'(1);
				end
				S_RSCAN: begin
					j_q <= j_q + CNT_W'(1);
					if (hit) rank_q <= rank_nx;
				end
				S_RDRAIN: begin
					if (!win) i_q <= last_i ? '0 : i_q + CNT_W'(1);
				end
				S_ECAP: begin
					out_last_q <= last_i;
				end
				S_EOUT: begin
					if (out_ready && !out_last_q) i_q <= i_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// datapath and result word registers
	always_ff @(posedge clk) begin
		jidx_s1 <= j_q;
		unique case (state_q)
			S_CHECK: begin
				dist_q        <= req_total_q - TOTAL_W'(pos_cnt_q);
				assigned_q    <= '0;
				out_idx_q     <= '0;
				out_shares_q  <= '0;
				out_status_q  <= chk_status;
				out_removed_q <= '0;
			end
			S_CMUL: begin
				prod_q    <= PROD_W'(dist_q) * PROD_W'(rd_rem[WEIGHT_BITS-1:0]);
				cur_pos_q <= rd_pos;
			end
			S_CWR: begin
				if (cur_pos_q) assigned_q <= assigned_q + div_quo[TOTAL_W-1:0];
			end
			S_LEFT: begin
				leftover_q <= left_nx;
			end
			S_RGET_I: begin
				cur_rem_q <= rd_rem;
			end
			S_ECAP: begin
				out_idx_q     <= IDX_OUT_W'(i_q);
				out_shares_q  <= rd_share;
				out_status_q  <= ST_OK;
				out_removed_q <= CNT_OUT_W'(load_cnt_q - pos_cnt_q);
			end
			default: begin
			end
		endcase
	end

	assign spot_index    = out_idx_q;
	assign shares        = out_shares_q;
	assign status        = out_status_q;
	assign removed_count = out_removed_q;
	assign weight_sum    = SUM_OUT_W'(sum_q);
	assign is_last       = out_last_q;

	// loading and result delivery never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a result word is pending");

	// an error run is one closing word with no shares
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (is_last && (shares == '0)))
		else $error("error result word malformed");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q <= CNT_W'(MAX_SPOTS))
		else $error("spot count beyond memory depth");

	// the divider has finished before its result is written back
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CWR) |-> !div_busy)
		else $error("write-back while divider busy");

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import lra_pkg::*;

	localparam int MAX_SPOTS_TB = MAX_SPOTS_DEF;
	localparam int WATCHDOG_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [WEIGHT_BITS_DEF-1:0] weight;
	logic last_weight;
	logic out_valid;
	logic out_ready;
	logic [IDX_OUT_W-1:0] spot_index;
	logic [SHARE_W-1:0] shares;
	logic [1:0] status;
	logic [CNT_OUT_W-1:0] removed_count;
	logic [SUM_OUT_W-1:0] weight_sum;
	logic is_last;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [TOTAL_W-1:0] cfg_data;

	largest_remainder_apportioner u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.weight(weight), .last_weight(last_weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.spot_index(spot_index), .shares(shares), .status(status),
		.removed_count(removed_count), .weight_sum(weight_sum), .is_last(is_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// one expected result word
	typedef struct packed {
		logic [IDX_OUT_W-1:0] idx;
		logic [SHARE_W-1:0] sh;
		status_t st;
		logic [CNT_OUT_W-1:0] rem;
		logic [SUM_OUT_W-1:0] sum;
		logic last;
	} share_word_t;

	share_word_t share_q[$];

	// predictor copy of the block's registers and run state
	logic [31:0] pr_total;
	logic [6:0] pr_spots;
	logic [23:0] pr_w[MAX_SPOTS_TB];
	int unsigned pr_loaded;
	longint unsigned pr_sum;
	int unsigned pr_pos;
	bit pr_over;

	int errors;
	bit idle_on;
	bit rx_idle_on;
	int quiet_cycles;
	bit done;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Apportion the stored list and queue the words it should emit.
	function automatic void apportion_list();
		status_t st;
		longint unsigned spread, assigned, prod;
		longint unsigned rmd[MAX_SPOTS_TB];
		logic [31:0] sh[MAX_SPOTS_TB];
		int unsigned rank, left;
		share_word_t wd;
		st = ST_OK;
		if (pr_over || pr_loaded != pr_spots) st = ST_COUNT;
		else if (pr_pos == 0 || pr_sum == 0) st = ST_NOPOS;
		else if (pr_total < pr_pos) st = ST_TOTAL;
		if (st != ST_OK) begin
			wd = '{idx: '0, sh: '0, st: st, rem: '0, sum: pr_sum[29:0], last: 1'b1};
			share_q = {share_q, wd};
		end else begin
			spread = longint'(pr_total) - pr_pos;
			assigned = 0;
			for (int i = 0; i < pr_loaded; i++) begin
				if (pr_w[i] == 0) begin
					sh[i] = 0;
					rmd[i] = 0;
				end else begin
					prod = spread * pr_w[i];
					rmd[i] = prod % pr_sum;
					sh[i] = 32'(1 + prod / pr_sum);
					assigned += prod / pr_sum;
				end
			end
			left = int'(spread - assigned);
			for (int i = 0; i < pr_loaded; i++) begin
				rank = 0;
				if (pr_w[i] != 0) begin
					for (int j = 0; j < pr_loaded; j++)
						if (j != i && pr_w[j] != 0 &&
						    (rmd[j] > rmd[i] || (rmd[j] == rmd[i] && j < i)))
							rank++;
					if (rank < left) sh[i]++;
				end
			end
			for (int k = 0; k < pr_loaded; k++) begin
				wd = '{idx: 6'(k), sh: sh[k], st: ST_OK, rem: 7'(pr_loaded - pr_pos),
					sum: pr_sum[29:0], last: (k + 1 == pr_loaded)};
				share_q = {share_q, wd};
			end
		end
		pr_loaded = 0;
		pr_sum = 0;
		pr_pos = 0;
		pr_over = 0;
	endfunction

	function automatic void absorb_weight(logic [23:0] w, logic lst);
		if (pr_loaded < MAX_SPOTS_TB) begin
			pr_w[pr_loaded] = w;
			pr_loaded++;
			pr_sum += w;
			if (w != 0) pr_pos++;
		end else
			pr_over = 1;
		if (lst) apportion_list();
	endfunction

	// Send one weight word; random idle before it unless idling is off.
	// Valid stays high into the next word; drain() drops it after a list.
	task automatic send_weight(logic [23:0] w, logic lst);
		while (idle_on && $urandom_range(99) < 11) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		weight <= w;
		last_weight <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		absorb_weight(w, lst);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [31:0] d);
		cfg_valid <= 1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (r == REG_TOTAL) pr_total = d;
		else pr_spots = d[6:0];
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (share_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Random list of n weights, small values to keep ties and zeros common.
	task automatic send_list(int n, bit wide);
		logic [23:0] w;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: w = 0;
				1: w = $urandom_range(3);
				default: w = wide ? 24'($urandom) : 24'($urandom_range(255));
			endcase
			send_weight(w, i == n - 1);
		end
	endtask

	// receiver: random stall, checks each word against the oldest expected one
	always @(negedge clk)
		out_ready <= !(rx_idle_on && $urandom_range(99) < 11);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			share_word_t e;
			if (share_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = share_q.pop_front();
				if (spot_index !== e.idx) begin
					$error("spot_index exp %0d got %0d", e.idx, spot_index); errors++;
				end
				if (shares !== e.sh) begin
					$error("shares exp %0d got %0d", e.sh, shares); errors++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); errors++;
				end
				if (removed_count !== e.rem) begin
					$error("removed_count exp %0d got %0d", e.rem, removed_count); errors++;
				end
				if (weight_sum !== e.sum) begin
					$error("weight_sum exp %0d got %0d", e.sum, weight_sum); errors++;
				end
				if (is_last !== e.last) begin
					$error("is_last exp %0d got %0d", e.last, is_last); errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted word on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT && !done) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Directed table: weight, last, then a typed-in expected error status
	// (ST_OK means the predictor decides).
	typedef struct {
		logic [23:0] w;
		logic lst;
		status_t st;
	} dir_row_t;

	dir_row_t dir_tab[] = '{
		'{24'd5, 1'b1, ST_OK},           // single spot, reset config
		'{24'd0, 1'b1, ST_NOPOS},        // only weight is zero
		'{24'd1, 1'b0, ST_OK},           // two words but spot_count 1
		'{24'd1, 1'b1, ST_COUNT},
		'{24'hFFFFFF, 1'b1, ST_OK}       // largest weight
	};

	initial begin
		errors = 0;
		done = 0;
		quiet_cycles = 0;
		idle_on = 1;
		rx_idle_on = 1;
		arst_n = 0;
		in_valid = 0;
		weight = 0;
		last_weight = 0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = REG_TOTAL;
		cfg_data = 0;
		pr_total = 1;
		pr_spots = 1;
		pr_loaded = 0;
		pr_sum = 0;
		pr_pos = 0;
		pr_over = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed table walk under reset configuration
		foreach (dir_tab[i]) begin
			send_weight(dir_tab[i].w, dir_tab[i].lst);
			if (dir_tab[i].st != ST_OK && share_q[share_q.size() - 1].st != dir_tab[i].st) begin
				$error("directed row %0d predictor status mismatch", i);
				errors++;
			end
		end
		drain();

		// total too small: three positive spots, total 2
		write_reg(REG_SPOTS, 7'd3);
		write_reg(REG_TOTAL, 32'd2);
		send_weight(24'd1, 0); send_weight(24'd2, 0); send_weight(24'd3, 1);
		drain();
		// ties on remainders, a zero spot, largest total
		write_reg(REG_TOTAL, 32'hFFFFFFFF);
		send_weight(24'd7, 0); send_weight(24'd0, 0); send_weight(24'd7, 1);
		drain();
		write_reg(REG_TOTAL, 32'd10);
		send_weight(24'd1, 0); send_weight(24'd1, 0); send_weight(24'd1, 1);
		drain();
		// spot count out of range: zero, and above the store size
		write_reg(REG_SPOTS, 7'd0);
		send_weight(24'd4, 1);
		drain();
		write_reg(REG_SPOTS, 7'd127);
		send_weight(24'd4, 1);
		drain();
		// full store, then one word too many
		write_reg(REG_SPOTS, 7'd64);
		write_reg(REG_TOTAL, 32'd1000);
		send_list(65, 1);
		drain();

		// random lists, mostly matching the configured count
		for (int ph = 0; ph < 10; ph++) begin
			int n;
			if (ph == 4) begin
				idle_on = 0;
				rx_idle_on = 0;
			end
			if (ph == 8) begin
				idle_on = 1;
				rx_idle_on = 1;
			end
			n = (ph == 9) ? 16 : $urandom_range(1, 5);
			write_reg(REG_SPOTS, 7'(n));
			case ($urandom_range(3))
				0: write_reg(REG_TOTAL, 32'($urandom_range(1, 12)));
				1: write_reg(REG_TOTAL, $urandom);
				default: write_reg(REG_TOTAL, 32'($urandom_range(1, 500)));
			endcase
			send_list(($urandom_range(9) == 0) ? n + 1 : n, ph[0]);
			drain();
		end

		done = 1;
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
